// ----- rtl/gcd_lcm_unit_macros.svh -----
// assertion macros for the gcd and lcm unit
// no dependencies; included by the modules that carry assertions
`ifndef GCD_LCM_UNIT_MACROS_SVH
`define GCD_LCM_UNIT_MACROS_SVH

// a property that must hold at every rising clock edge outside reset
`define GLU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// a property checked during reset as well
`define GLU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/glu_pkg.sv -----
// package for the gcd and lcm unit: widths, item types and state codes
// no dependencies
package glu_pkg;

    localparam int OperandBits  = 31;
    localparam int MultipleBits = 2 * OperandBits;
    localparam int CountBits    = $clog2(OperandBits + 1);
    localparam int QueueDepth   = 2;
    localparam int QueueAddrBits = 1;

    typedef logic [OperandBits-1:0]  t_operand;
    typedef logic [MultipleBits-1:0] t_multiple;

    // item kind decided by the front end
    typedef enum logic [1:0] {
        KIND_BOTH_ZERO = 2'd0,
        KIND_A_ZERO    = 2'd1,
        KIND_B_ZERO    = 2'd2,
        KIND_GENERAL   = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind    kind;
        t_operand first;
        t_operand second;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_GCD    = 3'd1,
        ST_DIV    = 3'd2,
        ST_MUL    = 3'd3,
        ST_OUTPUT = 3'd4
    } t_state;

endpackage

// ----- rtl/gcd_lcm_unit.sv -----
// gcd and lcm unit: top level joining the front end queue and the back end
// depends on glu_pkg, glu_front and glu_back
// Operands transfer in on i_valid/o_stall; a two-entry job queue decouples input from
// the arithmetic. The back end runs euclid as repeated restoring remainders (one per
// euclid step, data-dependent, at most about 45 steps), then divides the first operand
// by the gcd and multiplies by the second with shift-add; the result sits in an output
// register until taken. Zero operands skip all of that: the job is queued, then taken
// by the idle back end straight into the output state. The euclid steps and the divide
// of a general result both run on the single shared one-bit-per-cycle remainder unit.
// Nothing is kept between items and there is no clearing pass after reset.
module gcd_lcm_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  glu_pkg::t_operand  i_first_value,
    input  glu_pkg::t_operand  i_second_value,
    output logic               o_valid,
    input  logic               i_stall,
    output glu_pkg::t_operand  o_divisor,
    output glu_pkg::t_multiple o_multiple,
    output logic               o_both_zero
);
    import glu_pkg::*;

    // job queue hand-off
    logic job_valid, job_take;
    t_job job;

    glu_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_first_value, .i_second_value,
        .o_job_valid(job_valid), .i_job_take(job_take), .o_job(job)
    );

    glu_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(job_valid), .o_job_take(job_take), .i_job(job),
        .o_valid, .i_stall, .o_divisor, .o_multiple, .o_both_zero
    );

endmodule

// ----- rtl/glu_front.sv -----
// front end: accepts operand transfers, classifies them and queues the jobs
// depends on glu_pkg
module glu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  glu_pkg::t_operand i_first_value,
    input  glu_pkg::t_operand i_second_value,
    output logic              o_job_valid,
    input  logic              i_job_take,
    output glu_pkg::t_job     o_job
);
    import glu_pkg::*;

    t_job                   r_mem [QueueDepth];
    logic [QueueAddrBits:0] r_count, n_count;
    logic [QueueAddrBits-1:0] r_wr, r_rd;
    logic                   push, pop;
    t_job                   job_in;

    always_comb begin
        job_in.first  = i_first_value;
        job_in.second = i_second_value;
        if (i_first_value == '0 && i_second_value == '0) begin
            job_in.kind = KIND_BOTH_ZERO;
        end else if (i_first_value == '0) begin
            job_in.kind = KIND_A_ZERO;
        end else if (i_second_value == '0) begin
            job_in.kind = KIND_B_ZERO;
        end else begin
            job_in.kind = KIND_GENERAL;
        end
    end

    assign o_stall     = (r_count == (QueueAddrBits+1)'(QueueDepth));
    assign push        = i_valid && !o_stall;
    assign o_job_valid = (r_count != '0);
    assign pop         = o_job_valid && i_job_take;
    assign o_job       = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wr    <= '0;
            r_rd    <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= job_in;
        end
    end

endmodule

// ----- rtl/glu_back.sv -----
// back end: euclid by iterative restoring remainder, serial divide and multiply
// depends on glu_pkg and gcd_lcm_unit_macros.svh
`include "gcd_lcm_unit_macros.svh"
module glu_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    output logic               o_job_take,
    input  glu_pkg::t_job      i_job,
    output logic               o_valid,
    input  logic               i_stall,
    output glu_pkg::t_operand  o_divisor,
    output glu_pkg::t_multiple o_multiple,
    output logic               o_both_zero
);
    import glu_pkg::*;

    t_state r_state, n_state;
    // remainder unit: r_quo mod r_y, one quotient bit per cycle
    t_operand  r_y, r_a, r_b, r_rem, r_quo;
    t_operand  r_div;
    t_multiple r_acc, r_mcand;
    t_operand  r_mplier;
    logic [CountBits-1:0] r_cnt;
    logic      r_bz;

    logic [OperandBits:0] trial;
    logic [OperandBits:0] shifted;
    logic      step_last;

    assign shifted   = {r_rem, r_quo[OperandBits-1]};
    assign trial     = shifted - {1'b0, r_y};
    assign step_last = (r_cnt == CountBits'(OperandBits - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job.kind == KIND_GENERAL) ? ST_GCD : ST_OUTPUT;
                end
            end
            ST_GCD: begin
                if (step_last && trial[OperandBits] && shifted[OperandBits-1:0] == '0) begin
                    n_state = ST_DIV;
                end else if (step_last && !trial[OperandBits]
                             && trial[OperandBits-1:0] == '0) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (step_last) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (step_last) begin
                    n_state = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (!i_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_job_take = 1'b0;
        o_valid    = 1'b0;
        case (r_state)
            ST_IDLE:   o_job_take = i_job_valid;
            ST_OUTPUT: o_valid    = 1'b1;
            default: begin
                o_job_take = 1'b0;
                o_valid    = 1'b0;
            end
        endcase
    end

    assign o_divisor   = r_div;
    assign o_multiple  = r_acc;
    assign o_both_zero = r_bz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_a   <= i_job.first;
                r_b   <= i_job.second;
                r_y   <= i_job.second;
                r_quo <= i_job.first;
                r_rem <= '0;
                r_cnt <= '0;
                r_acc <= '0;
                r_bz  <= (i_job.kind == KIND_BOTH_ZERO);
                case (i_job.kind)
                    KIND_A_ZERO: r_div <= i_job.second;
                    KIND_B_ZERO: r_div <= i_job.first;
                    default:     r_div <= '0;
                endcase
            end
            ST_GCD: begin
                // one restoring step of r_quo mod r_y
                r_quo <= {r_quo[OperandBits-2:0], 1'b0};
                if (!trial[OperandBits]) begin
                    r_rem <= trial[OperandBits-1:0];
                end else begin
                    r_rem <= shifted[OperandBits-1:0];
                end
                r_cnt <= r_cnt + 1'b1;
                if (step_last) begin
                    r_cnt <= '0;
                    r_rem <= '0;
                    if (!trial[OperandBits] ? (trial[OperandBits-1:0] == '0)
                                             : (shifted[OperandBits-1:0] == '0)) begin
                        // remainder zero: gcd is r_y, start a / gcd
                        r_div <= r_y;
                        r_quo <= r_a;
                    end else begin
                        r_quo <= r_y;
                        r_y   <= !trial[OperandBits] ? trial[OperandBits-1:0]
                                                     : shifted[OperandBits-1:0];
                    end
                end
            end
            ST_DIV: begin
                // quotient bits shift into r_quo from the right
                r_quo <= {r_quo[OperandBits-2:0], !trial[OperandBits]};
                r_rem <= !trial[OperandBits] ? trial[OperandBits-1:0]
                                             : shifted[OperandBits-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (step_last) begin
                    r_cnt    <= '0;
                    r_mplier <= {r_quo[OperandBits-2:0], !trial[OperandBits]};
                    r_mcand  <= MultipleBits'(r_b);
                end
            end
            ST_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mplier <= r_mplier >> 1;
                r_mcand  <= r_mcand << 1;
                r_cnt    <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    `GLU_ASSERT(a_take_only_idle, o_job_take |-> (r_state == ST_IDLE),
                "job taken outside idle")
    `GLU_ASSERT(a_hold_output, (o_valid && i_stall) |=> (o_valid && $stable(r_div)
                && $stable(r_acc)), "stalled result changed")
    `GLU_ASSERT(a_zero_flag, (o_valid && r_bz) |-> (r_div == '0 && r_acc == '0),
                "both-zero result not cleared")
    `GLU_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == ST_IDLE),
                "not idle after reset")

endmodule
